[sv/cbm_pkg.sv]
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types and constants for the bank mapper with cycle-counter IRQ.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam logic [1:0] OP_CPU_WRITE = 2'd0;
  localparam logic [1:0] OP_CPU_READ  = 2'd1;
  localparam logic [1:0] OP_PPU_READ  = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRG_MASK = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHR_MASK = 8'd1;

  localparam logic [3:0] REGION_PRG0 = 4'h8;
  localparam logic [3:0] REGION_MISC = 4'h9;
  localparam logic [3:0] REGION_PRG1 = 4'hA;
  localparam logic [3:0] REGION_CHR  = 4'hB;

  localparam logic [2:0] MISC_SWAP      = 3'd0;
  localparam logic [2:0] MISC_MIRROR    = 3'd1;
  localparam logic [2:0] MISC_IRQ_EN    = 3'd3;
  localparam logic [2:0] MISC_IRQ_LOAD  = 3'd4;
  localparam logic [2:0] MISC_RELOAD_HI = 3'd5;
  localparam logic [2:0] MISC_RELOAD_LO = 3'd6;

  localparam logic [1:0] MSEL_VERTICAL   = 2'd0;
  localparam logic [1:0] MSEL_HORIZONTAL = 2'd2;

  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_SINGLE_LO  = 2'd2;

  localparam logic [7:0] PRG_FIXED_LOW  = 8'hFE;
  localparam logic [7:0] PRG_FIXED_HIGH = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [9:0]  cycles;
  } cbm_in_t;

  typedef struct packed {
    logic [20:0] mapped_offset;
    logic        mapped_hit;
    logic [1:0]  mirror_mode;
    logic        irq_line;
  } cbm_out_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [7:0]                data;
  } cbm_cfg_t;

  typedef struct packed {
    logic       tick;
    logic [9:0] cycles;
    logic       enable_we;
    logic       load;
    logic       reload_hi_we;
    logic       reload_lo_we;
    logic [7:0] data;
  } cbm_irq_ctl_t;

endpackage

`default_nettype wire

[sv/cbm_chan_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of a given type per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/cbm_irq.sv]
// ----------------------------------------------------------------------------
// IRQ timer
// Signed 16-bit down counter with reload latch, saturating at -32768.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_irq
  import cbm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cbm_irq_ctl_t ctl,
  output logic              irq_pending_nxt
);

  logic        irq_enable_r, irq_enable_nxt;
  logic        irq_pending_r;
  logic [15:0] irq_counter_r, irq_counter_nxt;
  logic [15:0] irq_reload_r, irq_reload_nxt;
  logic [16:0] diff;
  logic        fire;

  assign diff = {irq_counter_r[15], irq_counter_r} - {7'd0, ctl.cycles};
  assign fire = diff[16] || (diff == 17'd0);

  always_comb begin
    irq_enable_nxt  = irq_enable_r;
    irq_pending_nxt = irq_pending_r;
    irq_counter_nxt = irq_counter_r;
    irq_reload_nxt  = irq_reload_r;
    if (ctl.enable_we) begin
      irq_enable_nxt  = ctl.data[7];
      irq_pending_nxt = 1'b0;
    end
    if (ctl.load) begin
      irq_counter_nxt = irq_reload_r;
      irq_pending_nxt = 1'b0;
    end
    if (ctl.reload_hi_we) begin
      irq_reload_nxt = {ctl.data, irq_reload_r[7:0]};
    end
    if (ctl.reload_lo_we) begin
      irq_reload_nxt = {irq_reload_r[15:8], ctl.data};
    end
    if (ctl.tick && irq_enable_r) begin
      if (diff[16:15] == 2'b10) begin
        irq_counter_nxt = 16'h8000;
      end else begin
        irq_counter_nxt = diff[15:0];
      end
      if (fire) begin
        irq_pending_nxt = 1'b1;
        irq_enable_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_enable_r  <= 1'b0;
      irq_pending_r <= 1'b0;
      irq_counter_r <= 16'd0;
      irq_reload_r  <= 16'd0;
    end else begin
      irq_enable_r  <= irq_enable_nxt;
      irq_pending_r <= irq_pending_nxt;
      irq_counter_r <= irq_counter_nxt;
      irq_reload_r  <= irq_reload_nxt;
    end
  end

  // The request is only raised by the timer, which disables itself at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pending_r) |-> !irq_enable_r)
    else $error("IRQ raised while the timer is still enabled");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pending_r) |-> $signed(irq_counter_r) <= 16'sd0)
    else $error("IRQ raised with a positive counter");

  assert property (@(posedge clk) disable iff (!rst_n)
    !irq_enable_r && !ctl.load |=> $stable(irq_counter_r))
    else $error("Counter moved while the timer was disabled");

endmodule

`default_nettype wire

[sv/cbm_regs.sv]
// ----------------------------------------------------------------------------
// Mapper register file
// Decodes CPU writes into bank, swap and mirroring registers and timer controls.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_regs
  import cbm_pkg::*;
#(
  parameter int BANK_NUMBER_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire cbm_in_t                      item,
  output logic [BANK_NUMBER_BITS-1:0]       prg_bank [2],
  output logic [BANK_NUMBER_BITS-1:0]       chr_bank [8],
  output logic                              prg_swap,
  output logic [1:0]                        mirror_nxt,
  output cbm_irq_ctl_t                      irq_ctl
);

  logic [BANK_NUMBER_BITS-1:0] prg_bank_r [2];
  logic [BANK_NUMBER_BITS-1:0] chr_bank_r [8];
  logic                        prg_swap_r;
  logic [1:0]                  mirror_select_r, mirror_select_nxt;
  logic                        wr, prg_we, chr_we, misc_we;
  logic [3:0]                  region;
  logic [2:0]                  sub;

  assign wr     = go && (item.operation == OP_CPU_WRITE);
  assign region = item.address[15:12];
  assign sub    = item.address[2:0];

  always_comb begin
    prg_we  = 1'b0;
    chr_we  = 1'b0;
    misc_we = 1'b0;
    case (region)
      REGION_PRG0, REGION_PRG1: prg_we  = wr;
      REGION_MISC:              misc_we = wr;
      REGION_CHR:               chr_we  = wr;
      default: ;
    endcase
  end

  always_comb begin
    irq_ctl              = '0;
    irq_ctl.tick         = go && (item.operation == OP_TICK);
    irq_ctl.cycles       = item.cycles;
    irq_ctl.data         = item.data;
    irq_ctl.enable_we    = misc_we && (sub == MISC_IRQ_EN);
    irq_ctl.load         = misc_we && (sub == MISC_IRQ_LOAD);
    irq_ctl.reload_hi_we = misc_we && (sub == MISC_RELOAD_HI);
    irq_ctl.reload_lo_we = misc_we && (sub == MISC_RELOAD_LO);
  end

  always_comb begin
    mirror_select_nxt = mirror_select_r;
    if (misc_we && (sub == MISC_MIRROR)) begin
      mirror_select_nxt = item.data[7:6];
    end
    case (mirror_select_nxt)
      MSEL_VERTICAL:   mirror_nxt = MIRROR_VERTICAL;
      MSEL_HORIZONTAL: mirror_nxt = MIRROR_HORIZONTAL;
      default:         mirror_nxt = MIRROR_SINGLE_LO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r[0]   <= BANK_NUMBER_BITS'(0);
      prg_bank_r[1]   <= BANK_NUMBER_BITS'(1);
      for (int i = 0; i < 8; i++) begin
        chr_bank_r[i] <= BANK_NUMBER_BITS'(i);
      end
      prg_swap_r      <= 1'b0;
      mirror_select_r <= MSEL_VERTICAL;
    end else begin
      if (prg_we) begin
        prg_bank_r[item.address[13]] <= item.data[BANK_NUMBER_BITS-1:0];
      end
      if (chr_we) begin
        chr_bank_r[item.address[2:0]] <= item.data[BANK_NUMBER_BITS-1:0];
      end
      if (misc_we && (sub == MISC_SWAP)) begin
        prg_swap_r <= item.data[7];
      end
      mirror_select_r <= mirror_select_nxt;
    end
  end

  assign prg_bank = prg_bank_r;
  assign chr_bank = chr_bank_r;
  assign prg_swap = prg_swap_r;

endmodule

`default_nettype wire

[sv/cbm_xlate.sv]
// ----------------------------------------------------------------------------
// Address translator
// Turns a CPU or PPU read address into a PRG or CHR ROM byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_xlate
  import cbm_pkg::*;
#(
  parameter int BANK_NUMBER_BITS = 8
) (
  input  wire cbm_in_t                      item,
  input  wire logic [BANK_NUMBER_BITS-1:0]  prg_bank [2],
  input  wire logic [BANK_NUMBER_BITS-1:0]  chr_bank [8],
  input  wire logic                         prg_swap,
  input  wire logic [7:0]                   prg_mask,
  input  wire logic [7:0]                   chr_mask,
  output logic [20:0]                       mapped_offset,
  output logic                              mapped_hit
);

  localparam logic [BANK_NUMBER_BITS-1:0] FIXED_LOW  = PRG_FIXED_LOW[BANK_NUMBER_BITS-1:0];
  localparam logic [BANK_NUMBER_BITS-1:0] FIXED_HIGH = PRG_FIXED_HIGH[BANK_NUMBER_BITS-1:0];

  logic [BANK_NUMBER_BITS-1:0] prg_sel, prg_eff, chr_eff;

  always_comb begin
    case (item.address[14:13])
      2'd0:    prg_sel = prg_swap ? FIXED_LOW : prg_bank[0];
      2'd1:    prg_sel = prg_bank[1];
      2'd2:    prg_sel = prg_swap ? prg_bank[0] : FIXED_LOW;
      default: prg_sel = FIXED_HIGH;
    endcase
  end

  assign prg_eff = prg_sel & prg_mask[BANK_NUMBER_BITS-1:0];
  assign chr_eff = chr_bank[item.address[12:10]] & chr_mask[BANK_NUMBER_BITS-1:0];

  always_comb begin
    mapped_offset = 21'd0;
    mapped_hit    = 1'b0;
    case (item.operation)
      OP_CPU_READ: begin
        if (item.address[15]) begin
          mapped_offset = 21'({prg_eff, item.address[12:0]});
          mapped_hit    = 1'b1;
        end
      end
      OP_PPU_READ: begin
        if (item.address[15:13] == 3'd0) begin
          mapped_offset = 21'({chr_eff, item.address[9:0]});
          mapped_hit    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/cartridge_bank_mapper_with_irq.sv]
// ----------------------------------------------------------------------------
// Cartridge bank mapper with IRQ timer
// Top level: input register, mapper logic and result register.
// ----------------------------------------------------------------------------
// The input channel takes one transaction per item: a CPU register write, a
// CPU read to translate into a PRG ROM offset, a PPU read to translate into a
// CHR ROM offset, or a tick that counts the IRQ timer down by its amount. Every
// item gives exactly one result on the output channel, carrying the offset,
// the hit flag, the mirroring mode and the IRQ line as they stand after the
// item has taken effect.
// An item is registered on acceptance and its result is registered as the
// item leaves the input register, so one item can be accepted in every
// cycle while results are taken; the rate is set by the single pass through
// the write decode, timer subtractor and translation logic between the two.
// When the receiver stalls, the result register holds and the input register
// fills, after which the input channel drops ready until the result is taken.
// The configuration channel is always ready and sets the two bank masks.
// Reset clears all mapper state to its power-up values and sets both masks to
// all ones; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_with_irq
  import cbm_pkg::*;
#(
  parameter int BANK_NUMBER_BITS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbm_chan_if.sink    in_chan,
  cbm_chan_if.source  out_chan,
  cbm_chan_if.sink    cfg_chan
);

  logic                        s1_valid_r;
  cbm_in_t                     s1_item_r;
  logic                        s1_go;
  logic                        out_valid_r;
  cbm_out_t                    out_item_r;
  logic [7:0]                  prg_mask_r, chr_mask_r;
  logic [BANK_NUMBER_BITS-1:0] prg_bank [2];
  logic [BANK_NUMBER_BITS-1:0] chr_bank [8];
  logic                        prg_swap;
  logic [1:0]                  mirror_nxt;
  cbm_irq_ctl_t                irq_ctl;
  logic                        irq_pending_nxt;
  logic [20:0]                 mapped_offset;
  logic                        mapped_hit;
  cbm_in_t                     in_item;
  cbm_cfg_t                    cfg_item;

  assign in_item  = in_chan.payload;
  assign cfg_item = cfg_chan.payload;

  assign s1_go         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r <= 8'hFF;
      chr_mask_r <= 8'hFF;
    end else if (cfg_chan.valid) begin
      if (cfg_item.index == CFG_PRG_MASK) begin
        prg_mask_r <= cfg_item.data;
      end
      if (cfg_item.index == CFG_CHR_MASK) begin
        chr_mask_r <= cfg_item.data;
      end
    end
  end

  cbm_regs #(
    .BANK_NUMBER_BITS (BANK_NUMBER_BITS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .item       (s1_item_r),
    .prg_bank   (prg_bank),
    .chr_bank   (chr_bank),
    .prg_swap   (prg_swap),
    .mirror_nxt (mirror_nxt),
    .irq_ctl    (irq_ctl)
  );

  cbm_irq u_irq (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (irq_ctl),
    .irq_pending_nxt (irq_pending_nxt)
  );

  cbm_xlate #(
    .BANK_NUMBER_BITS (BANK_NUMBER_BITS)
  ) u_xlate (
    .item          (s1_item_r),
    .prg_bank      (prg_bank),
    .chr_bank      (chr_bank),
    .prg_swap      (prg_swap),
    .prg_mask      (prg_mask_r),
    .chr_mask      (chr_mask_r),
    .mapped_offset (mapped_offset),
    .mapped_hit    (mapped_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_item_r.mapped_offset <= mapped_offset;
      out_item_r.mapped_hit    <= mapped_hit;
      out_item_r.mirror_mode   <= mirror_nxt;
      out_item_r.irq_line      <= irq_pending_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

`default_nettype wire
